// ----- rtl/itbd_pkg.sv -----
// Shared types and constants for the integer to base digits converter.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps

package itbd_pkg;

   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [DIGIT_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [DIGIT_W-1:0] RADIX_MAX = 6'd36;

   localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'h30;
   // 'a' - 10: added to digit values 10..35
   localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'h57;
   localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic emit_step;
      logic flag_bad;
   } cmd_type;

   typedef struct packed {
      logic radix_bad;
      logic count_last;
      logic emit_hit;
   } stat_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] dx;
      dx = {1'b0, d};
      if (d < 6'd10) begin
         digit_to_char = ASCII_ZERO + dx;
      end else begin
         digit_to_char = ASCII_LETTER + dx;
      end
   endfunction

endpackage

// ----- rtl/itbd_datapath.sv -----
// Datapath: value shift register, base-radix digit register file with a
// doubling carry chain, step counter and character output.
// Depends on itbd_pkg.
`timescale 1ns / 1ps

module itbd_datapath #(
   parameter int VALUE_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  itbd_pkg::cmd_type         cmd,
   output itbd_pkg::stat_type        stat,
   input  logic [VALUE_BITS-1:0]     req_number,
   input  logic [5:0]                req_radix,
   output logic [6:0]                rsp_digit_char
);

   localparam int CW = $clog2(VALUE_BITS);
   localparam int DW = itbd_pkg::DIGIT_W;

   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [DW-1:0]         radix_ff, radix_in;
   logic [DW-1:0]         digit_ff [VALUE_BITS];
   logic [DW-1:0]         digit_in [VALUE_BITS];
   logic [DW-1:0]         conv_digit [VALUE_BITS];
   logic [VALUE_BITS:0]   carry;
   logic [CW-1:0]         count_ff, count_in;
   logic                  started_ff, started_in;
   logic [DW-1:0]         top_digit;
   logic                  count_last;

   assign top_digit  = digit_ff[VALUE_BITS-1];
   assign count_last = (count_ff == CW'(VALUE_BITS - 1));

   // Each cell computes 2*d + carry_in mod radix; carry out selected from
   // both precomputed compares so the chain is one mux per digit.
   assign carry[0] = value_ff[VALUE_BITS-1];

   for (genvar i = 0; i < VALUE_BITS; i++) begin : g_cell
      logic [DW:0] dbl;
      logic [DW:0] sum;
      logic [DW:0] rad;
      logic        ge0, ge1;
      assign dbl = {digit_ff[i], 1'b0};
      assign rad = {1'b0, radix_ff};
      assign ge0 = (dbl >= rad);
      assign ge1 = ({dbl[DW:1], 1'b1} >= rad);
      assign carry[i+1] = carry[i] ? ge1 : ge0;
      assign sum = {dbl[DW:1], carry[i]} - (carry[i+1] ? rad : '0);
      assign conv_digit[i] = sum[DW-1:0];
   end

   always_comb begin
      value_in   = value_ff;
      radix_in   = radix_ff;
      count_in   = count_ff;
      started_in = started_ff;
      for (int i = 0; i < VALUE_BITS; i++) begin
         digit_in[i] = digit_ff[i];
      end
      if (cmd.load) begin
         value_in   = req_number;
         radix_in   = req_radix;
         count_in   = '0;
         started_in = 1'b0;
         for (int i = 0; i < VALUE_BITS; i++) begin
            digit_in[i] = '0;
         end
      end else if (cmd.conv_step) begin
         value_in = {value_ff[VALUE_BITS-2:0], 1'b0};
         count_in = count_last ? '0 : count_ff + CW'(1);
         for (int i = 0; i < VALUE_BITS; i++) begin
            digit_in[i] = conv_digit[i];
         end
      end else if (cmd.emit_step) begin
         count_in   = count_last ? '0 : count_ff + CW'(1);
         started_in = started_ff | (top_digit != '0);
         digit_in[0] = '0;
         for (int i = 1; i < VALUE_BITS; i++) begin
            digit_in[i] = digit_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         started_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      radix_ff <= radix_in;
      for (int i = 0; i < VALUE_BITS; i++) begin
         digit_ff[i] <= digit_in[i];
      end
   end

   assign stat.radix_bad  = (req_radix < itbd_pkg::RADIX_MIN) ||
                            (req_radix > itbd_pkg::RADIX_MAX);
   assign stat.count_last = count_last;
   // leading zeros are skipped; the final slot always emits (zero value)
   assign stat.emit_hit   = started_ff || (top_digit != '0) || count_last;

   assign rsp_digit_char = cmd.flag_bad ? itbd_pkg::CHAR_NONE
                                        : itbd_pkg::digit_to_char(top_digit);

endmodule

// ----- rtl/itbd_controller.sv -----
// Controller: sequences load, conversion, digit emission and the bad-radix
// result. Depends on itbd_pkg.
`timescale 1ns / 1ps

module itbd_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  itbd_pkg::stat_type stat,
   output itbd_pkg::cmd_type  cmd,
   output logic               rsp_valid,
   output logic               rsp_last_digit,
   output logic               rsp_bad_radix
);

   itbd_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itbd_pkg::ST_IDLE: begin
            if (start) begin
               state_in = stat.radix_bad ? itbd_pkg::ST_BAD : itbd_pkg::ST_CONV;
            end
         end
         itbd_pkg::ST_CONV: begin
            if (stat.count_last) state_in = itbd_pkg::ST_EMIT;
         end
         itbd_pkg::ST_EMIT: begin
            if (stat.count_last) state_in = itbd_pkg::ST_IDLE;
         end
         itbd_pkg::ST_BAD: begin
            state_in = itbd_pkg::ST_IDLE;
         end
         default: state_in = itbd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      busy           = 1'b1;
      rsp_valid      = 1'b0;
      rsp_last_digit = 1'b0;
      rsp_bad_radix  = 1'b0;
      unique case (state_ff)
         itbd_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         itbd_pkg::ST_CONV: begin
            cmd.conv_step = 1'b1;
         end
         itbd_pkg::ST_EMIT: begin
            cmd.emit_step  = 1'b1;
            rsp_valid      = stat.emit_hit;
            rsp_last_digit = stat.count_last;
         end
         itbd_pkg::ST_BAD: begin
            cmd.flag_bad   = 1'b1;
            rsp_valid      = 1'b1;
            rsp_last_digit = 1'b1;
            rsp_bad_radix  = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itbd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/integer_to_base_digits.sv -----
// Top level of the integer to base digits converter: controller plus datapath.
// Depends on itbd_pkg, itbd_controller, itbd_datapath.
//
//   channel   ports                                           transfer
//   request   start, busy, req_number, req_radix              start && !busy
//   result    rsp_valid, rsp_digit_char, rsp_last_digit,      rsp_valid, one cycle
//             rsp_bad_radix
//
// A valid radix is converted by bit-serial doubling into the digit registers
// (one mux per digit in the carry chain), then the digits are shifted out
// through the emit slots, leading zeros dropped.
// A radix outside 2..36 gives its single flagged result.
// Reset clears the state machine, step counter and started flag; nothing else needs it.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module integer_to_base_digits #(
   parameter int VALUE_BITS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [63:0] req_number,
   input  logic [5:0]         req_radix,
   output logic               rsp_valid,
   output logic [6:0]         rsp_digit_char,
   output logic               rsp_last_digit,
   output logic               rsp_bad_radix
);

   itbd_pkg::cmd_type  cmd;
   itbd_pkg::stat_type stat;

   itbd_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .stat           (stat),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_last_digit (rsp_last_digit),
      .rsp_bad_radix  (rsp_bad_radix)
   );

   itbd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_number     (req_number[VALUE_BITS-1:0]),
      .req_radix      (req_radix),
      .rsp_digit_char (rsp_digit_char)
   );

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_digit) |=> !busy)
      else $error("still busy after final result");

   a_bad_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_bad_radix |-> (rsp_valid && rsp_last_digit && rsp_digit_char == 7'h00))
      else $error("flagged result malformed");

endmodule
